### rtl/bdll_pkg.sv
package bdll_pkg;

  localparam int Capacity   = 64;
  localparam int SlotBits   = $clog2(Capacity);
  localparam int CountBits  = $clog2(Capacity + 1);
  localparam int ValueWidth = 32;

  typedef logic [SlotBits-1:0]   slot_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [ValueWidth-1:0] value_t;

  // request codes
  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_INS_KEY   = 4'd3,
    OP_DEL_FRONT = 4'd4,
    OP_DEL_BACK  = 4'd5,
    OP_DEL_POS   = 4'd6,
    OP_DEL_KEY   = 4'd7,
    OP_LENGTH    = 4'd8
  } op_t;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOKEY = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE,
    DC_LOAD,       // latch request, cursor <= first
    DC_RD_CUR,     // read links and value at cursor
    DC_STEP,       // cursor <= next of cursor, step count +1
    DC_RD_PREV,    // read prev link of cursor into aux
    DC_POP,        // pop free slot into new slot
    DC_LINK_NEW,   // write value and links of new slot (before cursor)
    DC_LINK_NBR,   // write next of prev-of-cursor
    DC_LINK_NBR2,  // write prev of cursor, bump count, set first
    DC_UNLINK1,    // write next of prev neighbor
    DC_UNLINK2,    // write prev of next neighbor, count -1, push free
    DC_CUR_NEXT,   // cursor <= next of cursor (no count)
    DC_CUR_AUX     // cursor <= prev link read at cursor
  } dcmd_t;

  typedef struct packed {
    dcmd_t cmd;
    logic  set_first;   // new slot becomes first on link
  } ctl_t;

  typedef struct packed {
    count_t count;
    count_t steps;
    logic   match;       // value at cursor equals key
  } sts_t;

endpackage

### rtl/bounded_doubly_linked_list.sv
// Bounded doubly linked list of up to 64 signed 32-bit values held in a
// linked slot memory with a free-slot stack. One item is taken at a time.
// Length reports and requests refused for empty, full or range go from the
// check state straight to the done state; front and back deletes and inserts
// run their unlink or link states without a walk. Positional and key
// requests walk the links through the read, test and advance states for
// each slot, so the walk length sets their time. After reset the free stack
// is swept, during which no item is accepted. A result is held on out_*
// until taken, and the next item is accepted in the cycle after that at
// the earliest.
module bounded_doubly_linked_list
  import bdll_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic signed [31:0] in_value,
  input  logic [6:0]  in_position,
  input  logic signed [31:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_removed_value,
  output logic [6:0]  out_length
);

  ctl_t   ctl;
  sts_t   sts;
  value_t rd_value, rem;

  bdll_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .req_value(in_value), .req_key(in_key),
    .sts(sts), .rd_value(rd_value)
  );

  bdll_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_position(in_position),
    .sts(sts), .rd_value(rd_value), .ctl(ctl),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_removed_value(rem),
    .out_length(out_length)
  );

  assign out_removed_value = rem;

`ifndef SYNTHESIS
  // never more entries than slots
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= count_t'(Capacity))
    else $error("entry count overflow");
  // a result is never offered while an item is still being taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");
  // a non-ok result removes nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_removed_value == '0))
    else $error("failed request reported a removed value");
`endif

endmodule

### rtl/bdll_datapath.sv
module bdll_datapath
  import bdll_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ctl_t   ctl,
  input  value_t req_value,
  input  value_t req_key,
  output sts_t   sts,
  output value_t rd_value
);

  value_t slot_value [Capacity];
  slot_t  next_link  [Capacity];
  slot_t  prev_link  [Capacity];
  slot_t  free_stack [Capacity];

  count_t count_r, free_top_r, steps_r;
  slot_t  first_r, cur_r, aux_r, new_r, cnext_r, cprev_r;
  value_t val_r, key_r, cval_r;
  logic   init_r;
  slot_t  init_idx_r;

  assign sts.count = count_r;
  assign sts.steps = steps_r;
  assign sts.match = (cval_r == key_r);
  assign rd_value  = cval_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      free_top_r <= count_t'(Capacity);
      first_r    <= '0;
      steps_r    <= '0;
    end else begin
      unique case (ctl.cmd)
        DC_LOAD: begin
          steps_r <= '0;
        end
        DC_STEP: steps_r <= steps_r + 1'b1;
        DC_POP: free_top_r <= free_top_r - 1'b1;
        DC_LINK_NBR2: begin
          count_r <= count_r + 1'b1;
          if (ctl.set_first || count_r == '0) first_r <= new_r;
        end
        DC_UNLINK2: begin
          count_r    <= count_r - 1'b1;
          free_top_r <= free_top_r + 1'b1;
          if (count_r == count_t'(1)) first_r <= '0;
          else if (cur_r == first_r) first_r <= cnext_r;
        end
        default: ;
      endcase
    end
  end

  // free stack fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b1;
      init_idx_r <= '0;
    end else if (init_r) begin
      init_idx_r <= init_idx_r + 1'b1;
      if (init_idx_r == slot_t'(Capacity - 1)) init_r <= 1'b0;
    end
  end

  // free stack memory, swept after reset
  always_ff @(posedge clk) begin
    if (init_r) begin
      free_stack[init_idx_r] <= slot_t'(Capacity - 1) - init_idx_r;
    end else if (ctl.cmd == DC_UNLINK2) begin
      free_stack[free_top_r[SlotBits-1:0]] <= cur_r;
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      DC_LOAD: begin
        cur_r <= first_r;
        val_r <= req_value;
        key_r <= req_key;
      end
      DC_RD_CUR: begin
        cnext_r <= next_link[cur_r];
        cprev_r <= prev_link[cur_r];
        cval_r  <= slot_value[cur_r];
      end
      DC_STEP: cur_r <= cnext_r;
      DC_CUR_NEXT: cur_r <= cnext_r;
      DC_CUR_AUX: cur_r <= cprev_r;
      DC_RD_PREV: aux_r <= prev_link[cur_r];
      DC_POP: begin
        new_r <= free_stack[free_top_r[SlotBits-1:0] - 1'b1];
      end
      DC_LINK_NEW: begin
        slot_value[new_r] <= val_r;
        if (count_r == '0) begin
          next_link[new_r] <= new_r;
          prev_link[new_r] <= new_r;
        end else begin
          next_link[new_r] <= cur_r;
          prev_link[new_r] <= aux_r;
        end
      end
      DC_LINK_NBR: begin
        if (count_r != '0) next_link[aux_r] <= new_r;
      end
      DC_LINK_NBR2: begin
        if (count_r != '0) prev_link[cur_r] <= new_r;
      end
      DC_UNLINK1: begin
        if (count_r != count_t'(1)) next_link[cprev_r] <= cnext_r;
      end
      DC_UNLINK2: begin
        if (count_r != count_t'(1)) prev_link[cnext_r] <= cprev_r;
      end
      default: ;
    endcase
  end

endmodule

### rtl/bdll_ctrl.sv
module bdll_ctrl
  import bdll_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_opcode,
  input  logic [6:0] in_position,
  input  sts_t       sts,
  input  value_t     rd_value,
  output ctl_t       ctl,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output value_t     out_removed_value,
  output logic [6:0] out_length
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CHECK, S_RD, S_TEST, S_ADV,
    S_PREV, S_POP, S_LNEW, S_LNBR, S_LNBR2,
    S_URD, S_UN1, S_UN2, S_DONE, S_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] op_r;
  logic [6:0] pos_r;
  logic       setf_r, del_r, key_r, after_r;
  logic [5:0] init_cnt_r;
  logic [2:0] status_r;
  value_t     rem_r;
  logic [6:0] len_r;
  logic       ovalid_r;

  count_t target;
  assign target = (pos_r == 7'd0) ? '0 : count_t'(pos_r - 7'd1);

  assign in_stall          = (state_r != S_IDLE) || ovalid_r;
  assign out_valid         = ovalid_r;
  assign out_status        = status_r;
  assign out_removed_value = rem_r;
  assign out_length        = len_r;

  // command decode
  always_comb begin
    ctl.set_first = setf_r;
    unique case (state_r)
      S_IDLE:  ctl.cmd = (in_valid && !ovalid_r) ? DC_LOAD : DC_NONE;
      S_RD:    ctl.cmd = DC_RD_CUR;
      S_ADV:   ctl.cmd = DC_STEP;
      S_PREV:  ctl.cmd = DC_RD_PREV;
      S_POP:   ctl.cmd = DC_POP;
      S_LNEW:  ctl.cmd = DC_LINK_NEW;
      S_LNBR:  ctl.cmd = DC_LINK_NBR;
      S_LNBR2: ctl.cmd = DC_LINK_NBR2;
      S_URD:   ctl.cmd = DC_RD_CUR;
      S_UN1:   ctl.cmd = DC_UNLINK1;
      S_UN2:   ctl.cmd = DC_UNLINK2;
      default: ctl.cmd = DC_NONE;
    endcase
    if (state_r == S_TEST && after_r) ctl.cmd = DC_CUR_NEXT;
    if (state_r == S_CHECK && op_r == OP_DEL_BACK) ctl.cmd = DC_RD_CUR;
    if (state_r == S_RD && op_r == OP_DEL_BACK && after_r) ctl.cmd = DC_CUR_AUX;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      ovalid_r   <= 1'b0;
      init_cnt_r <= '0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == 6'(Capacity - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !ovalid_r) begin
            op_r    <= in_opcode;
            pos_r   <= in_position;
            rem_r   <= '0;
            status_r <= ST_OK;
            setf_r  <= 1'b0;
            after_r <= 1'b0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          del_r <= (op_r == OP_DEL_FRONT) || (op_r == OP_DEL_BACK) ||
                   (op_r == OP_DEL_POS) || (op_r == OP_DEL_KEY);
          key_r <= (op_r == OP_INS_KEY) || (op_r == OP_DEL_KEY);
          unique case (op_r)
            OP_INS_FRONT, OP_INS_BACK: begin
              if (sts.count == count_t'(Capacity)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                setf_r  <= (op_r == OP_INS_FRONT);
                state_r <= S_PREV;
              end
            end
            OP_INS_POS: begin
              if (sts.count == count_t'(Capacity)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else if (pos_r == 7'd0 || pos_r > 7'(sts.count) + 7'd1) begin
                status_r <= ST_RANGE;
                state_r  <= S_DONE;
              end else begin
                setf_r  <= (pos_r == 7'd1);
                state_r <= S_RD;
              end
            end
            OP_INS_KEY: begin
              if (sts.count == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else if (sts.count == count_t'(Capacity)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else state_r <= S_RD;
            end
            OP_DEL_FRONT: begin
              if (sts.count == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else state_r <= S_URD;
            end
            OP_DEL_BACK: begin
              if (sts.count == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else begin
                after_r <= 1'b1;
                state_r <= S_RD;
              end
            end
            OP_DEL_POS: begin
              if (sts.count == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else if (pos_r == 7'd0 || pos_r > 7'(sts.count)) begin
                status_r <= ST_RANGE;
                state_r  <= S_DONE;
              end else state_r <= S_RD;
            end
            OP_DEL_KEY: begin
              if (sts.count == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else state_r <= S_RD;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_RD: begin
          // back delete: cursor moved to prev of first
          if (op_r == OP_DEL_BACK) begin
            after_r <= 1'b0;
            state_r <= S_URD;
          end else state_r <= S_TEST;
        end
        S_TEST: begin
          if (after_r) begin
            // cursor now at successor of hit
            state_r <= S_PREV;
          end else if (key_r) begin
            if (sts.match) begin
              if (del_r) state_r <= S_UN1;
              else begin
                after_r <= 1'b1;
              end
            end else if (sts.steps + 1'b1 == sts.count) begin
              status_r <= ST_NOKEY;
              state_r  <= S_DONE;
            end else state_r <= S_ADV;
          end else if (sts.steps == target) begin
            state_r <= del_r ? S_UN1 : S_PREV;
          end else state_r <= S_ADV;
        end
        S_ADV:  state_r <= S_RD;
        S_PREV: state_r <= S_POP;
        S_POP:  state_r <= S_LNEW;
        S_LNEW: state_r <= S_LNBR;
        S_LNBR: state_r <= S_LNBR2;
        S_LNBR2: state_r <= S_DONE;
        S_URD:  state_r <= S_UN1;
        S_UN1: begin
          rem_r   <= rd_value;
          state_r <= S_UN2;
        end
        S_UN2:  state_r <= S_DONE;
        S_DONE: state_r <= S_OUT;
        S_OUT: begin
          len_r    <= 7'(sts.count);
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/bdll_checker.sv
module bdll_checker
  import bdll_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_key,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic signed [31:0] out_removed_value,
  input  logic [6:0]         out_length,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] removed;
    logic [6:0]  length;
  } answer_t;

  // predicted list kept as an ordered queue of values
  logic [31:0] list_q[$];
  answer_t     answer_q[$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int find_first(input logic [31:0] k);
    for (int i = 0; i < list_q.size(); i++)
      if (list_q[i] == k) return i;
    return -1;
  endfunction

  // compute the answer of one request and update the list
  function automatic answer_t apply_request(input logic [3:0] op, input logic [31:0] v,
                                            input logic [6:0] pos, input logic [31:0] k);
    answer_t a;
    int n;
    int hit;
    n = list_q.size();
    a = '0;
    a.status = ST_OK;
    case (op)
      OP_INS_FRONT: begin
        if (n >= Capacity) a.status = ST_FULL;
        else list_q.push_front(v);
      end
      OP_INS_BACK: begin
        if (n >= Capacity) a.status = ST_FULL;
        else list_q.push_back(v);
      end
      OP_INS_POS: begin
        if (n >= Capacity) a.status = ST_FULL;
        else if (pos == 0 || pos > n + 1) a.status = ST_RANGE;
        else list_q.insert(pos - 1, v);
      end
      OP_INS_KEY: begin
        if (n == 0) a.status = ST_EMPTY;
        else if (n >= Capacity) a.status = ST_FULL;
        else begin
          hit = find_first(k);
          if (hit < 0) a.status = ST_NOKEY;
          else list_q.insert(hit + 1, v);
        end
      end
      OP_DEL_FRONT: begin
        if (n == 0) a.status = ST_EMPTY;
        else a.removed = list_q.pop_front();
      end
      OP_DEL_BACK: begin
        if (n == 0) a.status = ST_EMPTY;
        else a.removed = list_q.pop_back();
      end
      OP_DEL_POS: begin
        if (n == 0) a.status = ST_EMPTY;
        else if (pos == 0 || pos > n) a.status = ST_RANGE;
        else begin
          a.removed = list_q[pos - 1];
          list_q.delete(pos - 1);
        end
      end
      OP_DEL_KEY: begin
        if (n == 0) a.status = ST_EMPTY;
        else begin
          hit = find_first(k);
          if (hit < 0) a.status = ST_NOKEY;
          else begin
            a.removed = list_q[hit];
            list_q.delete(hit);
          end
        end
      end
      default: ;
    endcase
    a.length = 7'(list_q.size());
    return a;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      list_q.delete();
      answer_q.delete();
      fail_count     = 0;
      pending_count <= 0;
      result_count  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (answer_q.size() == 0) begin
          report("result with no request waiting");
        end else begin
          exp_a = answer_q.pop_front();
          if (out_status !== exp_a.status)
            report($sformatf("status %0d, expected %0d", out_status, exp_a.status));
          if (out_removed_value !== exp_a.removed)
            report($sformatf("removed value %0d, expected %0d",
                             out_removed_value, $signed(exp_a.removed)));
          if (out_length !== exp_a.length)
            report($sformatf("length %0d, expected %0d", out_length, exp_a.length));
        end
      end
      if (in_valid && !in_stall)
        answer_q.push_back(apply_request(in_opcode, in_value, in_position, in_key));
      pending_count <= answer_q.size();
    end
  end

endmodule

### tb/bounded_doubly_linked_list_tb.sv
module bounded_doubly_linked_list_tb
  import bdll_pkg::*;
();

  localparam int RandomItems = 650;
  localparam int CycleLimit  = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_opcode;
  logic signed [31:0] in_value;
  logic [6:0]         in_position;
  logic signed [31:0] in_key;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic signed [31:0] out_removed_value;
  logic [6:0]         out_length;
  int                 fail_count;
  int                 pending_count;
  int                 result_count;
  int                 cycle_count = 0;
  int                 model_len;
  logic [31:0]        recent_values[$];
  bit                 stall_free;

  bounded_doubly_linked_list u_top (.*);

  bdll_checker u_checker (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int g;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_free) g = 0;
      else g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // send one item and wait for acceptance
  task automatic send_item(input logic [3:0] op, input logic [31:0] v,
                           input logic [6:0] pos, input logic [31:0] k);
    int g;
    g = stall_free ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value    <= v;
    in_position <= pos;
    in_key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // remember recently inserted values as keys for later requests
    if (op inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_POS, OP_INS_KEY}) begin
      recent_values.push_back(v);
      if (recent_values.size() > 16) void'(recent_values.pop_front());
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_key();
    if (recent_values.size() > 0 && $urandom_range(3) != 0)
      return recent_values[$urandom_range(recent_values.size() - 1)];
    return rand_value();
  endfunction

  initial begin
    int op;
    int len;
    int r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_opcode   = OP_LENGTH;
    in_value    = '0;
    in_position = '0;
    in_key      = '0;
    stall_free  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list cases
    send_item(OP_DEL_FRONT, 0, 0, 0);
    send_item(OP_DEL_BACK, 0, 0, 0);
    send_item(OP_DEL_POS, 0, 1, 0);
    send_item(OP_DEL_KEY, 0, 0, 5);
    send_item(OP_INS_KEY, 1, 0, 5);
    send_item(OP_INS_POS, 1, 0, 0);
    send_item(OP_INS_POS, 1, 2, 0);
    // directed: inserts, deletes, range and key misses, extremes, bad opcode, length
    send_item(OP_INS_POS, 32'h8000_0000, 1, 0);
    send_item(OP_INS_FRONT, 32'h7fff_ffff, 0, 0);
    send_item(OP_INS_BACK, 32'hffff_ffff, 0, 0);
    send_item(OP_INS_KEY, 7, 0, 32'h8000_0000);
    send_item(OP_INS_KEY, 8, 0, 32'h1234);
    send_item(OP_INS_POS, 9, 5, 0);
    send_item(OP_INS_POS, 9, 7'h7f, 0);
    send_item(OP_DEL_POS, 0, 0, 0);
    send_item(OP_DEL_POS, 0, 2, 0);
    send_item(OP_DEL_KEY, 0, 0, 9);
    send_item(OP_DEL_KEY, 0, 0, 32'h4321);
    send_item(4'd15, 32'h5555_aaaa, 7'h55, 32'haaaa_5555);
    send_item(OP_LENGTH, 0, 7'h2a, 0);
    // fill to capacity, hit full, then drain past empty
    stall_free = 1'b1;
    for (int i = 0; i < Capacity; i++) send_item(OP_INS_BACK, i, 0, 0);
    stall_free = 1'b0;
    send_item(OP_INS_FRONT, 1, 0, 0);
    send_item(OP_INS_POS, 1, 1, 0);
    send_item(OP_INS_KEY, 1, 0, 3);
    send_item(OP_DEL_POS, 0, 7'(Capacity), 0);
    send_item(OP_DEL_POS, 0, 7'(Capacity), 0);
    send_item(OP_DEL_KEY, 0, 0, 63);
    for (int i = 0; i < Capacity; i++) send_item(OP_DEL_FRONT, 0, 0, 0);

    // random part with a rough length estimate to steer deletes vs inserts
    len = 0;
    for (int i = 0; i < RandomItems; i++) begin
      r = $urandom_range(99);
      if (r < 3) op = $urandom_range(15, 9);
      else if (len < 8 || (len < 48 && r < 55)) op = $urandom_range(3);
      else op = $urandom_range(8);
      send_item(4'(op), rand_value(), 7'($urandom_range(len + 2)), rand_key());
      if (op <= OP_INS_KEY && len < Capacity) len++;
      else if (op >= OP_DEL_FRONT && op <= OP_DEL_KEY && len > 0) len--;
      len = out_length;
    end
    in_valid <= 1'b0;

    // drain
    while (pending_count != 0 || u_checker.answer_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("covered %0d results: every opcode, empty, full, range and key-miss cases",
             result_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/bdll_pkg.sv
rtl/bdll_datapath.sv
rtl/bdll_ctrl.sv
rtl/bounded_doubly_linked_list.sv
tb/bdll_checker.sv
tb/bounded_doubly_linked_list_tb.sv
